### rtl/core/bxf_pkg.sv
// bxf_pkg: shared constants and a helper for the 3x3 box filter stream block
// no dependencies

package bxf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_PIXEL_BITS = 16;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int FW_BITS    = 11;
    localparam int FH_BITS    = 13;

    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_HEIGHT = 2'd1;

    localparam int RST_WIDTH  = 1024;
    localparam int RST_HEIGHT = 1024;

    // clamp a frame dimension to [3, hi] and return its last index
    function automatic int clamp_last(input int v, input int hi);
        int c;
        begin
            if (v < 3) begin
                c = 3;
            end else if (v > hi) begin
                c = hi;
            end else begin
                c = v;
            end
            return c - 1;
        end
    endfunction

endpackage

### rtl/core/bxf_line_buf.sv
// bxf_line_buf: simple dual-port line buffer memory, registered read
// no dependencies

module bxf_line_buf #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 32,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/box_filter_3x3_stream.sv
// box_filter_3x3_stream: 3x3 mean filter over a raster-order pixel stream
// depends on bxf_pkg and bxf_line_buf
//
// usage:
//   slave stream takes one pixel word per handshake, row 0 first, column 0 first.
//   master stream gives result words: filtered interior pixels, border pixels
//   passed through, each tagged with its column and row. tlast marks the last
//   word caused by one input pixel, tuser marks pixel (W-1,H-1).
//   config port sets frame width and height; a write to either register restarts the frame.
//   path: pixel and line buffer read registered in stage 1, 9-term sum
//   registered in stage 2, multiply by reciprocal of 9 into the result words.
//   throughput: one pixel per cycle while the receiver is ready and each pixel
//   causes at most one word; a pixel with two or three words (right border, last
//   row) holds the output stage until all its words are taken and stalls the input.
//   when the receiver stalls, the pipeline fills and tready drops.
//   reset clears counters, window and pipeline; width and height return to 1024.
//   line buffers need no clearing: no result reads an unwritten entry.

module box_filter_3x3_stream
    import bxf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS,
    localparam int COL_W      = $clog2(MAX_WIDTH),
    localparam int ROW_W      = $clog2(MAX_HEIGHT),
    localparam int IN_DATA_W  = ((PIXEL_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((PIXEL_BITS + COL_W + ROW_W + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // pixel_in
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // pixel_out, out_col, out_row
    output logic                  o_m_axis_tlast,   // run_last
    output logic                  o_m_axis_tuser,   // frame_done
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SUM_W  = PIXEL_BITS + 4;
    localparam int DIV_K  = SUM_W + 4;
    localparam logic [63:0] DIV_M64 = ((64'd1 << DIV_K) + 64'd8) / 64'd9;
    localparam int MUL_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + MUL_W;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pix;
        logic [COL_W-1:0]      col;
        logic [ROW_W-1:0]      row;
        logic                  last;
        logic                  done;
    } t_result;

    // frame geometry and position
    logic [COL_W-1:0] r_w_last, n_w_last;
    logic [ROW_W-1:0] r_h_last, n_h_last;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    // stage 1: pixel and line buffer words
    logic                    r_s1_valid;
    logic [PIXEL_BITS-1:0]   r_s1_pix;
    logic [COL_W-1:0]        r_s1_col;
    logic [ROW_W-1:0]        r_s1_row;
    logic [2*PIXEL_BITS-1:0] lb_rd_data;
    logic [PIXEL_BITS-1:0]   s1_up2, s1_up1;
    logic [PIXEL_BITS-1:0]   r_win [6];
    logic [SUM_W-1:0]        s1_sum;

    // stage 2: sum and pass values
    logic                  r_s2_valid;
    logic [SUM_W-1:0]      r_s2_sum;
    logic [PIXEL_BITS-1:0] r_s2_pass;
    logic [PIXEL_BITS-1:0] r_s2_up1;
    logic [PIXEL_BITS-1:0] r_s2_pix;
    logic [COL_W-1:0]      r_s2_col;
    logic [ROW_W-1:0]      r_s2_row;
    logic                  r_s2_lag, r_s2_filt, r_s2_rb, r_s2_lr, r_s2_done;
    logic [PROD_W-1:0]     s2_prod;
    logic [PIXEL_BITS-1:0] s2_quot;

    // result words
    t_result    r_slot [3];
    t_result    n_slot [3];
    logic [1:0] r_left;
    logic [1:0] n_cnt;

    logic in_hs, out_hs, s1_adv, s2_adv, s1_en, s2_en, cfg_hit;

    assign out_hs = o_m_axis_tvalid && i_m_axis_tready;
    assign s2_adv = r_s2_valid && ((r_left == 2'd0) || ((r_left == 2'd1) && out_hs));
    assign s2_en  = !r_s2_valid || s2_adv;
    assign s1_adv = r_s1_valid && s2_en;
    assign s1_en  = !r_s1_valid || s1_adv;
    assign in_hs  = i_s_axis_tvalid && s1_en;

    assign o_s_axis_tready = s1_en;

    // config decode
    assign cfg_hit = i_cfg_we && ((i_cfg_addr == CFG_IDX_WIDTH) || (i_cfg_addr == CFG_IDX_HEIGHT));

    always_comb begin
        n_w_last = r_w_last;
        n_h_last = r_h_last;
        if (i_cfg_we && (i_cfg_addr == CFG_IDX_WIDTH)) begin
            n_w_last = COL_W'(clamp_last(int'(i_cfg_data[FW_BITS-1:0]), MAX_WIDTH));
        end
        if (i_cfg_we && (i_cfg_addr == CFG_IDX_HEIGHT)) begin
            n_h_last = ROW_W'(clamp_last(int'(i_cfg_data[FH_BITS-1:0]), MAX_HEIGHT));
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last   <= COL_W'(clamp_last(RST_WIDTH, MAX_WIDTH));
            r_h_last   <= ROW_W'(clamp_last(RST_HEIGHT, MAX_HEIGHT));
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_left     <= 2'd0;
        end else begin
            r_w_last <= n_w_last;
            r_h_last <= n_h_last;
            if (cfg_hit) begin
                r_col <= '0;
                r_row <= '0;
            end else if (in_hs) begin
                if (r_col == r_w_last) begin
                    r_col <= '0;
                    r_row <= (r_row == r_h_last) ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
            if (s1_en) begin
                r_s1_valid <= i_s_axis_tvalid;
            end
            if (s2_en) begin
                r_s2_valid <= s1_adv;
            end
            if (s2_adv) begin
                r_left <= n_cnt;
            end else if (out_hs) begin
                r_left <= r_left - 2'd1;
            end
        end
    end

    // line buffers: high half is row y-2, low half row y-1
    bxf_line_buf #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (2 * PIXEL_BITS),
        .ADDR_W (COL_W)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (in_hs),
        .i_rd_addr (r_col),
        .o_rd_data (lb_rd_data),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({s1_up1, r_s1_pix})
    );

    assign s1_up2 = lb_rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
    assign s1_up1 = lb_rd_data[PIXEL_BITS-1:0];

    always_comb begin
        s1_sum = SUM_W'(4) + SUM_W'(s1_up2) + SUM_W'(s1_up1) + SUM_W'(r_s1_pix)
               + SUM_W'(r_win[0]) + SUM_W'(r_win[1]) + SUM_W'(r_win[2])
               + SUM_W'(r_win[3]) + SUM_W'(r_win[4]) + SUM_W'(r_win[5]);
    end

    // window, reset to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_adv) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= s1_up2;
            r_win[4] <= s1_up1;
            r_win[5] <= r_s1_pix;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (in_hs) begin
            r_s1_pix <= i_s_axis_tdata[PIXEL_BITS-1:0];
            r_s1_col <= r_col;
            r_s1_row <= r_row;
        end
        if (s1_adv) begin
            r_s2_sum  <= s1_sum;
            r_s2_pass <= r_win[4];
            r_s2_up1  <= s1_up1;
            r_s2_pix  <= r_s1_pix;
            r_s2_col  <= r_s1_col;
            r_s2_row  <= r_s1_row;
            r_s2_lag  <= (r_s1_col != '0) && (r_s1_row != '0);
            r_s2_filt <= (r_s1_col >= COL_W'(2)) && (r_s1_row >= ROW_W'(2));
            r_s2_rb   <= (r_s1_col != '0) && (r_s1_row != '0) && (r_s1_col == r_w_last);
            r_s2_lr   <= (r_s1_row == r_h_last);
            r_s2_done <= (r_s1_col == r_w_last);
        end
    end

    // floor(sum / 9) by reciprocal multiply
    assign s2_prod = PROD_W'(r_s2_sum) * PROD_W'(DIV_M64[MUL_W-1:0]);
    assign s2_quot = s2_prod[DIV_K +: PIXEL_BITS];

    always_comb begin
        n_cnt = 2'd0;
        for (int i = 0; i < 3; i++) begin
            n_slot[i] = '0;
        end
        if (r_s2_lag) begin
            n_slot[n_cnt].pix = r_s2_filt ? s2_quot : r_s2_pass;
            n_slot[n_cnt].col = r_s2_col - COL_W'(1);
            n_slot[n_cnt].row = r_s2_row - ROW_W'(1);
            n_cnt = n_cnt + 2'd1;
        end
        if (r_s2_rb) begin
            n_slot[n_cnt].pix = r_s2_up1;
            n_slot[n_cnt].col = r_s2_col;
            n_slot[n_cnt].row = r_s2_row - ROW_W'(1);
            n_cnt = n_cnt + 2'd1;
        end
        if (r_s2_lr) begin
            n_slot[n_cnt].pix  = r_s2_pix;
            n_slot[n_cnt].col  = r_s2_col;
            n_slot[n_cnt].row  = r_s2_row;
            n_slot[n_cnt].done = r_s2_done;
            n_cnt = n_cnt + 2'd1;
        end
        if (n_cnt != 2'd0) begin
            n_slot[n_cnt - 2'd1].last = 1'b1;
        end
    end

    // result words shift toward the output
    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_slot[0] <= n_slot[0];
            r_slot[1] <= n_slot[1];
            r_slot[2] <= n_slot[2];
        end else if (out_hs) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

    assign o_m_axis_tvalid = (r_left != 2'd0);
    assign o_m_axis_tdata  = OUT_DATA_W'({r_slot[0].row, r_slot[0].col, r_slot[0].pix});
    assign o_m_axis_tlast  = r_slot[0].last;
    assign o_m_axis_tuser  = r_slot[0].done;

endmodule
